>>> src/bdlp_pkg.sv
// bdlp_pkg: shared types and constants of the button debouncer
// no dependencies
`default_nettype none

package bdlp_pkg;

  // width of the scan age counters
  localparam int unsigned AGE_WIDTH = 16;

  // register field widths
  localparam int unsigned DEB_WIDTH   = 8;
  localparam int unsigned LONG_WIDTH  = 16;
  localparam int unsigned TOTAL_WIDTH = 32;

  // configuration port
  localparam int unsigned CFG_IDX_WIDTH  = 8;
  localparam int unsigned CFG_DATA_WIDTH = 16;

  // compare width for age against a limit
  localparam int unsigned CMP_WIDTH = (AGE_WIDTH > LONG_WIDTH) ? AGE_WIDTH : LONG_WIDTH;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DEBOUNCE_SCANS   = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LONG_PRESS_SCANS = CFG_IDX_WIDTH'(1);

  // register reset values
  localparam logic [DEB_WIDTH-1:0]  DEB_RESET  = DEB_WIDTH'(3);
  localparam logic [LONG_WIDTH-1:0] LONG_RESET = LONG_WIDTH'(100);

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2,
    EV_LONG     = 2'd3
  } event_e;

  typedef struct packed {
    logic [DEB_WIDTH-1:0]  debounce_scans;
    logic [LONG_WIDTH-1:0] long_press_scans;
  } cfg_t;

  // input stage contents
  typedef struct packed {
    logic valid;
    logic level;
  } scan_t;

  // saturating advance of an age counter
  function automatic logic [AGE_WIDTH-1:0] age_advance(input logic [AGE_WIDTH-1:0] a);
    age_advance = (a == {AGE_WIDTH{1'b1}}) ? a : a + AGE_WIDTH'(1);
  endfunction

endpackage

`default_nettype wire

>>> src/bdlp_cfg_regs.sv
// bdlp_cfg_regs: debounce and long-press limit registers
// depends on bdlp_pkg
`default_nettype none

module bdlp_cfg_regs (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_valid_i,
  input  wire logic [bdlp_pkg::CFG_IDX_WIDTH-1:0]   cfg_index_i,
  input  wire logic [bdlp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i,
  output bdlp_pkg::cfg_t                             cfg_o
);
  import bdlp_pkg::*;

  logic [DEB_WIDTH-1:0]  deb_q;
  logic [LONG_WIDTH-1:0] long_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q  <= DEB_RESET;
      long_q <= LONG_RESET;
    end else if (cfg_valid_i) begin
      // indexes beyond the list are dropped
      unique case (cfg_index_i)
        REG_DEBOUNCE_SCANS:   deb_q  <= cfg_data_i[DEB_WIDTH-1:0];
        REG_LONG_PRESS_SCANS: long_q <= cfg_data_i[LONG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.debounce_scans   = deb_q;
  assign cfg_o.long_press_scans = long_q;

endmodule

`default_nettype wire

>>> src/bdlp_in_stage.sv
// bdlp_in_stage: input register for one scan beat
// depends on bdlp_pkg
`default_nettype none

module bdlp_in_stage (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire logic     raw_level_i,
  input  wire logic     take_i,
  output bdlp_pkg::scan_t scan_o
);
  import bdlp_pkg::*;

  logic valid_d, valid_q;
  logic level_q;
  logic load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      level_q <= raw_level_i;
    end
  end

  assign scan_o.valid = valid_q;
  assign scan_o.level = level_q;

endmodule

`default_nettype wire

>>> src/bdlp_step.sv
// bdlp_step: debounce state, per-scan update logic and result register
// depends on bdlp_pkg
`default_nettype none

module bdlp_step (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  bdlp_pkg::cfg_t                            cfg_i,
  input  bdlp_pkg::scan_t                           scan_i,
  output logic                                      take_o,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [1:0]                                event_code_o,
  output logic                                      debounced_level_o,
  output logic [bdlp_pkg::TOTAL_WIDTH-1:0]          press_count_o,
  output logic [bdlp_pkg::TOTAL_WIDTH-1:0]          long_press_count_o
);
  import bdlp_pkg::*;

  logic                   waiting_q, waiting_d;
  logic                   stable_q, stable_d;
  logic [AGE_WIDTH-1:0]   change_age_q, change_age_d;
  logic [AGE_WIDTH-1:0]   press_age_q, press_age_d;
  logic                   long_rep_q, long_rep_d;
  logic [TOTAL_WIDTH-1:0] press_total_q, press_total_d;
  logic [TOTAL_WIDTH-1:0] long_total_q, long_total_d;
  event_e                 ev_q, ev_d;
  logic                   out_valid_q;
  logic [AGE_WIDTH-1:0]   press_adv, change_adv;
  logic                   differs;

  // result register frees when empty or being taken
  assign take_o   = scan_i.valid && (!out_valid_q || !out_stall_i);
  assign differs  = scan_i.level != stable_q;
  assign press_adv  = age_advance(press_age_q);
  assign change_adv = age_advance(change_age_q);

  always_comb begin
    waiting_d     = waiting_q;
    stable_d      = stable_q;
    change_age_d  = change_age_q;
    press_age_d   = press_adv;
    long_rep_d    = long_rep_q;
    press_total_d = press_total_q;
    long_total_d  = long_total_q;
    ev_d          = EV_NONE;
    if (!waiting_q) begin
      if (differs) begin
        change_age_d = '0;
        waiting_d    = 1'b1;
      end else if (stable_q && !long_rep_q) begin
        if (CMP_WIDTH'(press_adv) >= CMP_WIDTH'(cfg_i.long_press_scans)) begin
          ev_d         = EV_LONG;
          long_rep_d   = 1'b1;
          long_total_d = long_total_q + TOTAL_WIDTH'(1);
        end
      end
    end else begin
      change_age_d = change_adv;
      if (CMP_WIDTH'(change_adv) >= CMP_WIDTH'(cfg_i.debounce_scans)) begin
        if (differs) begin
          stable_d = scan_i.level;
          if (scan_i.level) begin
            ev_d          = EV_PRESSED;
            press_age_d   = '0;
            long_rep_d    = 1'b0;
            press_total_d = press_total_q + TOTAL_WIDTH'(1);
          end else begin
            ev_d = EV_RELEASED;
          end
        end
        waiting_d = 1'b0;
      end else if (!differs) begin
        waiting_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q     <= 1'b0;
      stable_q      <= 1'b0;
      change_age_q  <= '0;
      press_age_q   <= '0;
      long_rep_q    <= 1'b0;
      press_total_q <= '0;
      long_total_q  <= '0;
      ev_q          <= EV_NONE;
      out_valid_q   <= 1'b0;
    end else begin
      if (take_o) begin
        waiting_q     <= waiting_d;
        stable_q      <= stable_d;
        change_age_q  <= change_age_d;
        press_age_q   <= press_age_d;
        long_rep_q    <= long_rep_d;
        press_total_q <= press_total_d;
        long_total_q  <= long_total_d;
        ev_q          <= ev_d;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // state only moves together with a new result, so it mirrors the held beat
  assign out_valid_o        = out_valid_q;
  assign event_code_o       = ev_q;
  assign debounced_level_o  = stable_q;
  assign press_count_o      = press_total_q;
  assign long_press_count_o = long_total_q;

  a_press_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ev_q == EV_PRESSED |-> stable_q)
    else $error("press event with released level");

  a_release_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ev_q == EV_RELEASED |-> !stable_q)
    else $error("release event with pressed level");

  a_long_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && ev_d == EV_LONG |=> long_total_q == $past(long_total_q) + TOTAL_WIDTH'(1))
    else $error("long-press total did not advance");

  a_long_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && ev_d == EV_LONG |-> !long_rep_q && stable_q)
    else $error("long press reported twice");

endmodule

`default_nettype wire

>>> src/button_debounce_long_press.sv
// button_debounce_long_press: top level of the scan-based button debouncer
// depends on bdlp_pkg, bdlp_cfg_regs, bdlp_in_stage, bdlp_step
//
// usage
// - input channel: one beat per button scan, raw_level_i = 1 when pressed,
//   accepted at a clock edge with in_valid_i high and in_stall_o low
// - output channel: one result beat per scan beat, in order, accepted at an
//   edge with out_valid_o high and out_stall_i low; event_code_o gives
//   none / pressed / released / long press, plus the debounced level and
//   the wrapping press and long-press totals after that scan
// - path: an accepted scan passes the input register, then the update logic
//   into the result register, which then raises out_valid_o
// - throughput: 1 beat per cycle while out_stall_i is low; the state update
//   is a single pass of short counter and compare logic between the input
//   and result registers
// - stall: while the result register is held, the input register still takes
//   one more beat; only then in_stall_o rises
// - config: cfg_index_i 0 sets debounce_scans, 1 sets long_press_scans,
//   other indexes are ignored; cfg_ready_o is always high; write only while
//   the block is drained
// - reset: asynchronous, clears all state to idle/released with zero ages
//   and totals, limits back to 3 and 100 scans
`default_nettype none

module button_debounce_long_press (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration writes
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [bdlp_pkg::CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  wire logic [bdlp_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i,
  // scan beats
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 raw_level_i,
  // result beats
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [1:0]                                event_code_o,
  output logic                                      debounced_level_o,
  output logic [bdlp_pkg::TOTAL_WIDTH-1:0]          press_count_o,
  output logic [bdlp_pkg::TOTAL_WIDTH-1:0]          long_press_count_o
);
  import bdlp_pkg::*;

  cfg_t  cfg;
  scan_t scan;
  logic  take;

  // register writes are never back-pressured
  assign cfg_ready_o = 1'b1;

  bdlp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // holds the scan until the update stage can take it
  bdlp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .raw_level_i (raw_level_i),
    .take_i      (take),
    .scan_o      (scan)
  );

  // debounce state machine and result register
  bdlp_step u_step (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .scan_i             (scan),
    .take_o             (take),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .event_code_o       (event_code_o),
    .debounced_level_o  (debounced_level_o),
    .press_count_o      (press_count_o),
    .long_press_count_o (long_press_count_o)
  );

endmodule

`default_nettype wire
